// ----- sv/mmt_pkg.sv -----
// shared types and constants for the markov motif train and score core
`timescale 1ns / 1ps

package mmt_pkg;

    // default sizes
    localparam int MAX_LEN_DEF   = 32;
    localparam int MAX_ORDER_DEF = 2;
    localparam int COUNT_W_DEF   = 24;

    // fixed field widths
    localparam int POS_W  = 7;
    localparam int PROB_W = 17;
    localparam int MANT_W = 16;
    localparam int EXP_W  = 13;
    localparam int TRN_W  = 24;
    localparam int SH_W   = 5;
    localparam int PROD_W = MANT_W + PROB_W;

    localparam logic [PROB_W-1:0] QUARTER  = PROB_W'(16384);
    localparam logic [MANT_W-1:0] ONE_MANT = MANT_W'(32768);
    localparam logic signed [EXP_W-1:0] EXP_MIN = -EXP_W'(4096);
    localparam logic [TRN_W-1:0] TRN_MAX = {TRN_W{1'b1}};

    // register indexes
    localparam logic [1:0] REG_LEN    = 2'd0;
    localparam logic [1:0] REG_ORDER  = 2'd1;
    localparam logic [1:0] REG_SPREAD = 2'd2;
    localparam logic [1:0] REG_PCOUNT = 2'd3;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_TRAIN = 2'd1,
        CMD_SCORE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_TRD,
        ST_TWR,
        ST_TFIN,
        ST_SREAD,
        ST_SSUM,
        ST_SDIV,
        ST_MUL,
        ST_NORM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- sv/mmt_div.sv -----
// bit-serial divider for the rounded probability quotient
`timescale 1ns / 1ps

module mmt_div
    import mmt_pkg::*;
#(
    parameter int COUNT_W = COUNT_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [COUNT_W-1:0]   i_cnt,
    input  logic [COUNT_W+1:0]   i_sum,
    output t_div_sts             o_sts,
    output logic [PROB_W-1:0]    o_quot
);

    localparam int SUM_W = COUNT_W + 2;
    localparam int NUM_W = COUNT_W + PROB_W;

    logic               r_busy;
    logic               r_done;
    logic [SH_W-1:0]    r_step;
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_den;
    logic [PROB_W-1:0]  r_num;
    logic [PROB_W-1:0]  r_quot;

    logic [NUM_W-1:0]   num_full;
    logic [SUM_W:0]     trial;
    logic               q_bit;

    // numerator is count * 2^16 plus half the sum
    assign num_full = NUM_W'({i_cnt, 16'h0000}) + NUM_W'(i_sum >> 1);
    assign trial    = {r_rem, r_num[PROB_W-1]};
    assign q_bit    = (trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SH_W'(PROB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= SUM_W'(num_full[NUM_W-1:PROB_W]);
            r_num  <= num_full[PROB_W-1:0];
            r_den  <= i_sum;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= q_bit ? SUM_W'(trial - {1'b0, r_den}) : trial[SUM_W-1:0];
            r_num  <= {r_num[PROB_W-2:0], 1'b0};
            r_quot <= {r_quot[PROB_W-2:0], q_bit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

// ----- sv/markov_motif_train_and_score_core.sv -----
// top level: count table memory, sequencer and product normalisation
`timescale 1ns / 1ps
// Markov motif model core: trains and scores one nucleotide per input transaction.
// Input channel i_in_valid/o_in_ready carries cmd, base, first_of_sequence and
// train_weight; result channel o_out_valid/i_out_ready carries one result at most.
// The count table sits in one single-port memory, one row of four counts per
// position and context, so scoring reads a whole row in one access.
// Work per item, set by the sequencer and the memory port:
//   train: one read and one write back per trained entry, at most
//          2*spread+1 entries
//   score: a row read, the serial divider and normalising shifts (up to 17);
//          an invalid window or zero sum skips the divider
//   clear: one row per cycle over 4^MAX_ORDER*MAX_LEN rows (512 by default)
//   context bases and bases past the motif: no result
// One item is in flight at a time; o_in_ready is high only when idle.
// A finished result waits in an output register, so the next item may be
// accepted while the receiver stalls; the sequencer holds before emitting only
// if that register is still full.
// After reset the block sweeps the table to the pseudocount and accepts no
// item until done; configuration writes are taken.

module markov_motif_train_and_score_core
    import mmt_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int COUNT_W   = COUNT_W_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // apb configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic [2:0]               i_base,
    input  logic                     i_first_of_sequence,
    input  logic [15:0]              i_train_weight,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [PROB_W-1:0]        o_base_prob,
    output logic [MANT_W-1:0]        o_prod_mantissa,
    output logic signed [EXP_W-1:0]  o_prod_exponent,
    output logic                     o_last_of_run,
    output logic [TRN_W-1:0]         o_sequences_trained,
    output logic                     o_clear_done
);

    localparam int RPP    = 1 << (2 * MAX_ORDER);
    localparam int ROWS   = MAX_LEN * RPP;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CTX_W  = (MAX_ORDER > 0) ? 2 * MAX_ORDER : 2;
    localparam int SUM_W  = COUNT_W + 2;
    localparam int DATA_W = 4 * COUNT_W;
    localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

    // configuration registers
    logic [5:0] r_len;
    logic [1:0] r_order;
    logic [4:0] r_spread;
    logic [7:0] r_pcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= 6'd8;
            r_order  <= 2'd0;
            r_spread <= 5'd0;
            r_pcnt   <= 8'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LEN:    r_len    <= pwdata[5:0];
                REG_ORDER:  r_order  <= pwdata[1:0];
                REG_SPREAD: r_spread <= pwdata[4:0];
                REG_PCOUNT: r_pcnt   <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LEN:    prdata = {26'd0, r_len};
            REG_ORDER:  prdata = {30'd0, r_order};
            REG_SPREAD: prdata = {27'd0, r_spread};
            REG_PCOUNT: prdata = {24'd0, r_pcnt};
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // effective order and length
    logic [1:0]       eff_k;
    logic [POS_W-1:0] eff_n;
    assign eff_k = ({1'b0, r_order} > 3'(MAX_ORDER)) ? 2'(MAX_ORDER) : r_order;
    always_comb begin
        if (r_len == 6'd0) begin
            eff_n = POS_W'(1);
        end else if ({3'd0, r_len} > 9'(MAX_LEN)) begin
            eff_n = POS_W'(MAX_LEN);
        end else begin
            eff_n = POS_W'(r_len);
        end
    end

    // state
    t_state                    r_state, n_state;
    logic [1:0]                r_cmd;
    logic [2:0]                r_base;
    logic                      r_first;
    logic [15:0]               r_wt;
    logic [CTX_W-1:0]          r_ctx, n_ctx;
    logic [1:0]                r_age, n_age;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [MANT_W-1:0]         r_mant, n_mant;
    logic signed [EXP_W-1:0]   r_exp, n_exp;
    logic [TRN_W-1:0]          r_trained, n_trained;
    logic [POS_W-1:0]          r_p, n_p;
    logic [POS_W-1:0]          r_q, n_q;
    logic [POS_W-1:0]          r_hi, n_hi;
    logic [CTX_W-1:0]          r_crow, n_crow;
    logic [1:0]                r_lane, n_lane;
    logic [PROB_W-1:0]         r_prob, n_prob;
    logic [PROD_W-1:0]         r_t, n_t;
    logic [SH_W-1:0]           r_sh, n_sh;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [COUNT_W-1:0]        r_cnt, n_cnt;
    logic [ROW_W-1:0]          r_clr_addr, n_clr_addr;
    logic                      r_clr_cmd, n_clr_cmd;
    logic                      r_last, n_last;
    logic                      r_res_clr, n_res_clr;
    logic                      r_out_valid, n_out_valid;
    logic [PROB_W-1:0]         r_o_prob, n_o_prob;
    logic [MANT_W-1:0]         r_o_mant, n_o_mant;
    logic signed [EXP_W-1:0]   r_o_exp, n_o_exp;
    logic                      r_o_last, n_o_last;
    logic [TRN_W-1:0]          r_o_trn, n_o_trn;
    logic                      r_o_clr, n_o_clr;

    // count table memory
    logic [DATA_W-1:0] mem [ROWS];
    logic [DATA_W-1:0] r_rd;
    logic              mem_we, mem_re;
    logic [ROW_W-1:0]  mem_addr;
    logic [DATA_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[mem_addr];
        end
    end

    // divider
    logic              div_start;
    t_div_sts          div_sts;
    logic [PROB_W-1:0] div_quot;

    mmt_div #(
        .COUNT_W (COUNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_cnt   (r_cnt),
        .i_sum   (r_sum),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // helper signals
    logic [POS_W-1:0]        pos0, p0, lo0, sum_ps, kn;
    logic [CTX_W-1:0]        ctx0, kmask, ctx_sh;
    logic [1:0]              age0;
    logic                    bad, wbad;
    logic [ROW_W-1:0]        row_addr;
    logic [COUNT_W-1:0]      lane_cnt;
    logic [COUNT_W:0]        lane_add;
    logic [DATA_W-1:0]       upd_row;
    logic [SUM_W-1:0]        row_sum;
    logic signed [EXP_W:0]   e_new;

    always_comb begin
        pos0 = r_first ? '0 : r_pos;
        ctx0 = r_first ? '0 : r_ctx;
        age0 = r_first ? 2'd0 : r_age;
        for (int i = 0; i < CTX_W; i++) begin
            kmask[i] = (i < 2 * int'(eff_k));
        end
        kn     = POS_W'(eff_k) + eff_n;
        bad    = (r_base > 3'd3);
        wbad   = bad || (age0 != 2'd0);
        p0     = pos0 - POS_W'(eff_k);
        lo0    = (p0 >= POS_W'(r_spread)) ? (p0 - POS_W'(r_spread)) : '0;
        sum_ps = p0 + POS_W'(r_spread);
        ctx_sh = CTX_W'({ctx0, r_base[1:0]});
        row_addr = ROW_W'((int'(r_q) << (2 * MAX_ORDER)) + int'(r_crow));
        lane_cnt = r_rd[r_lane*COUNT_W +: COUNT_W];
        lane_add = {1'b0, lane_cnt} + (COUNT_W+1)'(r_wt);
        upd_row  = r_rd;
        upd_row[r_lane*COUNT_W +: COUNT_W] = lane_add[COUNT_W] ? CNT_MAX
                                                                : lane_add[COUNT_W-1:0];
        row_sum = '0;
        for (int i = 0; i < 4; i++) begin
            row_sum = row_sum + SUM_W'(r_rd[i*COUNT_W +: COUNT_W]);
        end
        e_new = (EXP_W+1)'(r_exp) + (EXP_W+1)'(1) - (EXP_W+1)'(r_sh);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ctx       = r_ctx;
        n_age       = r_age;
        n_pos       = r_pos;
        n_mant      = r_mant;
        n_exp       = r_exp;
        n_trained   = r_trained;
        n_p         = r_p;
        n_q         = r_q;
        n_hi        = r_hi;
        n_crow      = r_crow;
        n_lane      = r_lane;
        n_prob      = r_prob;
        n_t         = r_t;
        n_sh        = r_sh;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_clr_addr  = r_clr_addr;
        n_clr_cmd   = r_clr_cmd;
        n_last      = r_last;
        n_res_clr   = r_res_clr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_prob    = r_o_prob;
        n_o_mant    = r_o_mant;
        n_o_exp     = r_o_exp;
        n_o_last    = r_o_last;
        n_o_trn     = r_o_trn;
        n_o_clr     = r_o_clr;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = row_addr;
        mem_wdata   = upd_row;
        div_start   = 1'b0;
        o_in_ready  = 1'b0;

        case (r_state)
            // sweep every row to the pseudocount
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = {4{COUNT_W'(r_pcnt)}};
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ROW_W'(ROWS - 1)) begin
                    n_clr_addr = '0;
                    if (r_clr_cmd) begin
                        n_prob    = '0;
                        n_last    = 1'b0;
                        n_res_clr = 1'b1;
                        n_state   = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_START;
                end
            end

            // decode the captured transaction
            ST_START: begin
                n_res_clr = 1'b0;
                n_prob    = '0;
                n_last    = 1'b0;
                case (t_cmd'(r_cmd))
                    CMD_CLEAR: begin
                        n_trained = '0;
                        n_clr_cmd = 1'b1;
                        n_state   = ST_CLEAR;
                    end
                    CMD_TRAIN, CMD_SCORE: begin
                        n_state = ST_IDLE;
                        if (r_first) begin
                            n_pos  = '0;
                            n_ctx  = '0;
                            n_age  = 2'd0;
                            n_mant = ONE_MANT;
                            n_exp  = '0;
                        end
                        if (pos0 < kn) begin
                            n_ctx  = ctx_sh & {CTX_W{(MAX_ORDER > 0)}};
                            n_age  = bad ? eff_k : ((age0 != 2'd0) ? age0 - 2'd1 : 2'd0);
                            n_pos  = pos0 + 1'b1;
                            n_crow = ctx0 & kmask;
                            n_lane = r_base[1:0];
                            n_p    = p0;
                            if (pos0 >= POS_W'(eff_k)) begin
                                n_last = (p0 + 1'b1 == eff_n);
                                if (t_cmd'(r_cmd) == CMD_TRAIN) begin
                                    n_last = 1'b0;
                                    n_q    = lo0;
                                    n_hi   = (sum_ps >= eff_n) ? eff_n - 1'b1 : sum_ps;
                                    n_state = wbad ? ST_TFIN : ST_TRD;
                                end else if (wbad) begin
                                    n_prob  = QUARTER;
                                    n_state = ST_MUL;
                                end else begin
                                    n_q     = p0;
                                    n_state = ST_SREAD;
                                end
                            end
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            // read, modify and write back one entry: ST_TRD reads, ST_TWR writes
            ST_TRD: begin
                mem_re  = 1'b1;
                n_state = ST_TWR;
            end

            ST_TWR: begin
                mem_we = 1'b1;
                if (r_q == r_hi) begin
                    n_state = ST_TFIN;
                end else begin
                    n_q     = r_q + 1'b1;
                    n_state = ST_TRD;
                end
            end

            ST_TFIN: begin
                if ((r_p + 1'b1 == eff_n) && (r_trained != TRN_MAX)) begin
                    n_trained = r_trained + 1'b1;
                end
                n_state = ST_EMIT;
            end

            ST_SREAD: begin
                mem_re  = 1'b1;
                n_state = ST_SSUM;
            end

            ST_SSUM: begin
                n_sum   = row_sum;
                n_cnt   = lane_cnt;
                n_state = ST_SDIV;
                if (row_sum == '0) begin
                    n_prob  = QUARTER;
                    n_state = ST_MUL;
                end
            end

            ST_SDIV: begin
                if (!div_sts.busy && !div_sts.done) begin
                    div_start = 1'b1;
                end
                if (div_sts.done) begin
                    n_prob  = div_quot;
                    n_state = ST_MUL;
                end
            end

            // multiply into the running product
            ST_MUL: begin
                n_state = ST_EMIT;
                if (r_mant != '0) begin
                    if (r_prob == '0) begin
                        n_mant = '0;
                        n_exp  = EXP_MIN;
                    end else begin
                        n_t     = PROD_W'(r_mant) * PROD_W'(r_prob);
                        n_sh    = '0;
                        n_state = ST_NORM;
                    end
                end
            end

            // shift left until the top bit is set
            ST_NORM: begin
                if (r_t[PROD_W-1]) begin
                    if (e_new < (EXP_W+1)'(EXP_MIN)) begin
                        n_mant = '0;
                        n_exp  = EXP_MIN;
                    end else begin
                        n_mant = r_t[PROD_W-1 -: MANT_W];
                        n_exp  = EXP_W'(e_new);
                    end
                    n_state = ST_EMIT;
                end else begin
                    n_t  = {r_t[PROD_W-2:0], 1'b0};
                    n_sh = r_sh + 1'b1;
                end
            end

            // load the output register once it is free
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_prob    = r_prob;
                    n_o_mant    = r_mant;
                    n_o_exp     = r_exp;
                    n_o_last    = r_last;
                    n_o_trn     = r_trained;
                    n_o_clr     = r_res_clr;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ctx       <= '0;
            r_age       <= 2'd0;
            r_pos       <= '0;
            r_mant      <= ONE_MANT;
            r_exp       <= '0;
            r_trained   <= '0;
            r_clr_addr  <= '0;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctx       <= n_ctx;
            r_age       <= n_age;
            r_pos       <= n_pos;
            r_mant      <= n_mant;
            r_exp       <= n_exp;
            r_trained   <= n_trained;
            r_clr_addr  <= n_clr_addr;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd   <= i_cmd;
            r_base  <= i_base;
            r_first <= i_first_of_sequence;
            r_wt    <= i_train_weight;
        end
        r_p       <= n_p;
        r_q       <= n_q;
        r_hi      <= n_hi;
        r_crow    <= n_crow;
        r_lane    <= n_lane;
        r_prob    <= n_prob;
        r_t       <= n_t;
        r_sh      <= n_sh;
        r_sum     <= n_sum;
        r_cnt     <= n_cnt;
        r_last    <= n_last;
        r_res_clr <= n_res_clr;
        r_o_prob  <= n_o_prob;
        r_o_mant  <= n_o_mant;
        r_o_exp   <= n_o_exp;
        r_o_last  <= n_o_last;
        r_o_trn   <= n_o_trn;
        r_o_clr   <= n_o_clr;
    end

    assign o_out_valid         = r_out_valid;
    assign o_base_prob         = r_o_prob;
    assign o_prod_mantissa     = r_o_mant;
    assign o_prod_exponent     = r_o_exp;
    assign o_last_of_run       = r_o_last;
    assign o_sequences_trained = r_o_trn;
    assign o_clear_done        = r_o_clr;

`ifndef SYNTHESIS
    // product stays normalised, and zero carries the floor exponent
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mant != '0) |-> r_mant[MANT_W-1])
        else $error("product mantissa not normalised");

    a_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mant == '0) |-> (r_exp == EXP_MIN))
        else $error("zero product with wrong exponent");

    // normalisation never starts from an empty product
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> (r_t != '0))
        else $error("normalising a zero product");

    // divider is quiet whenever a new transaction can be taken
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_sts.busy)
        else $error("divider busy while idle");
`endif

endmodule
